// ===== design/b64e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the Base64 symbol map for the stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned GROUPS_PER_LINE = 19;
  localparam int unsigned LINE_CNT_W      = 5;
  localparam int unsigned PADDR_W         = 3;

  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  // word index of the line wrap enable register
  localparam logic REG_WRAP = 1'b0;

  // position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    POS0 = 2'd0,
    POS1 = 2'd1,
    POS2 = 2'd2
  } pos_t;

  // up to four characters produced by one byte; last_idx = count - 1
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
  } group_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'd65;          // 'A'..'Z'
    end else if (v < 6'd52) begin
      return w + 8'd71;          // 'a'..'z'
    end else if (v < 6'd62) begin
      return w - 8'd4;           // '0'..'9'
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

// ===== design/b64e_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_if
// Valid/ready channels: raw byte input and character output.
// ----------------------------------------------------------------------------
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

// ===== design/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard alphabet, with optional 76-column wrap.
// ----------------------------------------------------------------------------
// Path: a byte accepted on the input passes through the input register, then
//   the character group register, before its first character is on the output.
// Throughput: one character per cycle while the output is ready; a new byte is
//   taken once the previous byte's group loads, and a byte makes 1-4 characters.
// Reset (rst, synchronous): clears group position, leftover bits, line count,
//   the wrap enable and all valid flags; no clearing pass.
module base64_stream_encoder (
  input  logic                          clk,
  input  logic                          rst,
  b64e_in_if.sink                       in,
  b64e_out_if.source                    out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [b64e_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic             wrap_en;
  logic             grp_valid;
  logic             grp_ready;
  b64e_pkg::group_t grp;

  b64e_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .wrap_en    (wrap_en)
  );

  b64e_encode u_encode (
    .clk        (clk),
    .rst        (rst),
    .wrap_en    (wrap_en),
    .in         (in),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready),
    .grp        (grp)
  );

  b64e_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out       (out)
  );

endmodule

// ===== design/b64e_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_regs
// APB-style configuration register file (line wrap enable).
// ----------------------------------------------------------------------------
module b64e_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [b64e_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic                          wrap_en
);

  logic wr_en;
  logic hit_wrap;

  // byte lanes are ignored; decode on the word index
  assign hit_wrap = (paddr[2] == b64e_pkg::REG_WRAP);
  assign wr_en    = psel && penable && pwrite && hit_wrap;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_en <= 1'b0;
    end else if (wr_en) begin
      wrap_en <= pwdata[0];
    end
  end

  assign prdata = hit_wrap ? {31'd0, wrap_en} : 32'd0;

endmodule

// ===== design/b64e_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_encode
// Input register plus group state; maps one byte to its character group.
// ----------------------------------------------------------------------------
module b64e_encode (
  input  logic                clk,
  input  logic                rst,
  input  logic                wrap_en,
  b64e_in_if.sink             in,
  output logic                grp_valid,
  input  logic                grp_ready,
  output b64e_pkg::group_t    grp
);

  logic       a_valid;
  logic [7:0] a_data;
  logic       a_last;
  logic       a_move;

  b64e_pkg::pos_t                     pos;
  b64e_pkg::pos_t                     pos_next;
  logic [3:0]                         leftover;
  logic [3:0]                         leftover_next;
  logic [b64e_pkg::LINE_CNT_W-1:0]    line_cnt;
  logic [b64e_pkg::LINE_CNT_W-1:0]    line_cnt_next;
  logic [b64e_pkg::LINE_CNT_W-1:0]    line_inc;

  assign a_move    = a_valid && grp_ready;
  assign in.ready  = !a_valid || grp_ready;
  assign grp_valid = a_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in.ready) begin
      a_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      a_data <= in.data_byte;
      a_last <= in.last_byte;
    end
  end

  always_comb begin
    grp           = '0;
    pos_next      = pos;
    leftover_next = leftover;
    line_cnt_next = line_cnt;
    line_inc      = line_cnt + b64e_pkg::LINE_CNT_W'(1);
    unique case (pos)
      b64e_pkg::POS1: begin
        grp.chars[0]  = b64e_pkg::sym({leftover[1:0], a_data[7:4]});
        leftover_next = a_data[3:0];
        pos_next      = b64e_pkg::POS2;
        if (a_last) begin
          grp.chars[1] = b64e_pkg::sym({a_data[3:0], 2'b00});
          grp.chars[2] = b64e_pkg::CHAR_PAD;
          grp.last_idx = 2'd2;
        end
      end
      b64e_pkg::POS2: begin
        grp.chars[0]  = b64e_pkg::sym({leftover, a_data[7:6]});
        grp.chars[1]  = b64e_pkg::sym(a_data[5:0]);
        grp.last_idx  = 2'd1;
        leftover_next = 4'd0;
        pos_next      = b64e_pkg::POS0;
        line_cnt_next = line_inc;
        if (line_inc >= b64e_pkg::LINE_CNT_W'(b64e_pkg::GROUPS_PER_LINE)) begin
          line_cnt_next = '0;
          if (wrap_en) begin
            grp.chars[2] = b64e_pkg::CHAR_NEWLINE;
            grp.last_idx = 2'd2;
          end
        end
      end
      default: begin
        grp.chars[0]  = b64e_pkg::sym(a_data[7:2]);
        leftover_next = {2'b00, a_data[1:0]};
        pos_next      = b64e_pkg::POS1;
        if (a_last) begin
          grp.chars[1] = b64e_pkg::sym({a_data[1:0], 4'b0000});
          grp.chars[2] = b64e_pkg::CHAR_PAD;
          grp.chars[3] = b64e_pkg::CHAR_PAD;
          grp.last_idx = 2'd3;
        end
      end
    endcase
    // end of message: next byte starts a fresh group and line
    if (a_last) begin
      pos_next      = b64e_pkg::POS0;
      leftover_next = 4'd0;
      line_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= b64e_pkg::POS0;
      leftover <= 4'd0;
      line_cnt <= '0;
    end else if (a_move) begin
      pos      <= pos_next;
      leftover <= leftover_next;
      line_cnt <= line_cnt_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    a_move && a_last |=> pos == b64e_pkg::POS0 && leftover == 4'd0 && line_cnt == '0)
    else $error("state not cleared after final byte");

  line_cnt_range: assert property (@(posedge clk) disable iff (rst)
    line_cnt < b64e_pkg::LINE_CNT_W'(b64e_pkg::GROUPS_PER_LINE))
    else $error("line group count out of range");

  leftover_pos1: assert property (@(posedge clk) disable iff (rst)
    pos == b64e_pkg::POS1 |-> leftover[3:2] == 2'b00)
    else $error("leftover holds more than two bits after first byte");

endmodule

// ===== design/b64e_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_serializer
// Result register holding one character group; sends one character per beat.
// ----------------------------------------------------------------------------
module b64e_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              grp_valid,
  output logic              grp_ready,
  input  b64e_pkg::group_t  grp,
  b64e_out_if.source        out
);

  logic             b_valid;
  b64e_pkg::group_t buf_grp;
  logic [1:0]       idx;
  logic             at_end;
  logic             take;

  assign at_end    = (idx == buf_grp.last_idx);
  // a new group may load in the cycle the final character leaves
  assign grp_ready = !b_valid || (out.ready && at_end);
  assign take      = grp_valid && grp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      idx     <= 2'd0;
    end else if (take) begin
      b_valid <= 1'b1;
      idx     <= 2'd0;
    end else if (b_valid && out.ready) begin
      if (at_end) begin
        b_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_grp <= grp;
    end
  end

  assign out.valid    = b_valid;
  assign out.out_char = buf_grp.chars[idx];
  assign out.out_last = at_end;

  idx_in_group: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> idx <= buf_grp.last_idx)
    else $error("character index past end of group");

endmodule

// ===== verif/tb_base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking bench for the streaming Base64 encoder. A directed table
// (extremes, padding and flush cases, typed expectations where obvious) is
// followed by wrap-point messages, a mid-message wrap change and random
// messages under four idling phases. Each output beat is checked against a typed
// row or an in-bench encoder that tracks group position, leftover bits and line count.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
  import b64e_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_PAUSE = 6;
  localparam int unsigned MAX_GAP     = 40;
  localparam int unsigned IDX_SPARE   = 1;
  localparam logic [PADDR_W-1:0] ADDR_WRAP  = PADDR_W'(4 * REG_WRAP);
  localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4 * IDX_SPARE);
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [2:0]  n_typed;   // 0: expectation comes from the encoder model
    logic [31:0] typed;     // right-justified, first char in the top used byte
  } byte_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .in      (in_ch),
    .out     (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder model state
  pos_t        enc_pos;
  logic [3:0]  enc_left;
  logic [4:0]  enc_lines;
  logic        cfg_wrap;

  enc_char_t   expected_chars[$];
  byte_row_t   directed_rows[$];
  enc_char_t   got_entry;

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned chars_checked;
  int unsigned bytes_sent;
  int unsigned messages_sent;
  int unsigned newlines_seen;
  int unsigned cycle_count;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return B64_ALPHABET[8*(63 - v) +: 8];
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // advance the model by one byte; chars[k] is the k-th character out
  task automatic encode_byte(input logic [7:0] d, input logic l,
                             output int n, output logic [3:0][7:0] chars);
    n = 0;
    chars = '0;
    case (enc_pos)
      POS1: begin
        chars[0] = b64_char({enc_left[1:0], d[7:4]});
        n = 1;
        enc_left = d[3:0];
        enc_pos = POS2;
        if (l) begin
          chars[1] = b64_char({enc_left, 2'b00});
          chars[2] = CHAR_PAD;
          n = 3;
        end
      end
      POS2: begin
        chars[0] = b64_char({enc_left, d[7:6]});
        chars[1] = b64_char(d[5:0]);
        n = 2;
        enc_left = '0;
        enc_pos = POS0;
        enc_lines = enc_lines + 5'd1;
        if (enc_lines >= GROUPS_PER_LINE) begin
          enc_lines = '0;
          if (cfg_wrap) begin
            chars[2] = CHAR_NEWLINE;
            n = 3;
          end
        end
      end
      default: begin
        chars[0] = b64_char(d[7:2]);
        n = 1;
        enc_left = {2'b00, d[1:0]};
        enc_pos = POS1;
        if (l) begin
          chars[1] = b64_char({d[1:0], 4'b0000});
          chars[2] = CHAR_PAD;
          chars[3] = CHAR_PAD;
          n = 4;
        end
      end
    endcase
    if (l) begin
      enc_pos = POS0;
      enc_left = '0;
      enc_lines = '0;
    end
  endtask

  // one beat on the byte channel; expectations are queued at acceptance
  task automatic send_byte(input logic [7:0] d, input logic l,
                           input int n_typed, input logic [31:0] typed);
    int unsigned gap;
    int n;
    logic [3:0][7:0] chars;
    enc_char_t e;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_byte(d, l, n, chars);
    if (n_typed > 0) begin
      for (int k = 0; k < n_typed; k++) begin
        e.ch = typed[8*(n_typed - 1 - k) +: 8];
        e.last = (k == n_typed - 1);
        expected_chars.push_back(e);
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        e.ch = chars[k];
        e.last = (k == n - 1);
        expected_chars.push_back(e);
      end
    end
    bytes_sent++;
    if (l) messages_sent++;
  endtask

  task automatic send_run(input int len, input bit end_msg);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), end_msg && (i == len - 1), 0, '0);
  endtask

  // stop the byte channel and let the encoder go idle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // returns with the bus idle again so that calls can follow directly
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                            input logic [31:0] d, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_wrap_reg;
    logic [31:0] rd;
    apb_access(1'b0, ADDR_WRAP, '0, rd);
    if (rd !== {31'b0, cfg_wrap})
      note_mismatch($sformatf("wrap enable readback exp %h got %h", {31'b0, cfg_wrap}, rd));
  endtask

  task automatic set_wrap(input logic w);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_WRAP, {31'($urandom_range(32'h7fff_ffff)), w}, rd);
    cfg_wrap = w;
    check_wrap_reg();
  endtask

  task automatic add_row(input logic [7:0] d, input logic l, input int n,
                         input logic [31:0] s);
    byte_row_t r;
    r.data = d;
    r.last = l;
    r.n_typed = 3'(n);
    r.typed = s;
    directed_rows.push_back(r);
  endtask

  // random messages: mostly short, some around the wrap point, a little noise
  task automatic run_random(input int n_items);
    int left;
    int r;
    logic l;
    left = 0;
    repeat (n_items) begin
      if (left == 0) begin
        r = $urandom_range(99);
        if (r < 70) left = $urandom_range(8, 1);
        else if (r < 88) left = $urandom_range(60, 55);
        else left = $urandom_range(120, 110);
      end
      l = (left == 1);
      if ($urandom_range(9) == 0) l = 1'($urandom_range(1));
      send_byte(8'($urandom_range(255)), l, 0, '0);
      left = l ? 0 : left - 1;
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected beat char %h last %b",
                                out_ch.out_char, out_ch.out_last));
      end else begin
        got_entry = expected_chars.pop_front();
        chars_checked++;
        if (got_entry.ch == CHAR_NEWLINE) newlines_seen++;
        if (out_ch.out_char !== got_entry.ch)
          note_mismatch($sformatf("out_char exp %h got %h", got_entry.ch, out_ch.out_char));
        if (out_ch.out_last !== got_entry.last)
          note_mismatch($sformatf("out_last exp %b got %b (char %h)",
                                  got_entry.last, out_ch.out_last, got_entry.ch));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, expected_chars.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    chars_checked = 0;
    bytes_sent = 0;
    messages_sent = 0;
    newlines_seen = 0;
    cycle_count = 0;
    enc_pos = POS0;
    enc_left = '0;
    enc_lines = '0;
    cfg_wrap = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_wrap_reg();

    // directed table
    add_row(8'h00, 1'b1, 4, "AA==");
    add_row(8'hFF, 1'b1, 4, "/w==");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b1, 3, "/8=");
    add_row(8'h00, 1'b0, 1, "A");
    add_row(8'h00, 1'b0, 1, "A");
    add_row(8'h00, 1'b1, 2, "AA");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b0, 2, "//");
    add_row(8'h00, 1'b1, 4, "AA==");
    add_row(8'h4D, 1'b0, 0, '0);
    add_row(8'h61, 1'b0, 0, '0);
    add_row(8'h6E, 1'b0, 0, '0);
    add_row(8'hF8, 1'b0, 1, "+");
    add_row(8'h0F, 1'b0, 0, '0);
    add_row(8'hBF, 1'b1, 0, '0);
    add_row(8'h80, 1'b0, 0, '0);
    add_row(8'h01, 1'b0, 0, '0);
    add_row(8'h7F, 1'b0, 0, '0);
    add_row(8'hA5, 1'b0, 0, '0);
    add_row(8'h5A, 1'b1, 0, '0);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].n_typed, directed_rows[i].typed);
    drain();

    // message ending exactly on a wrap point
    set_wrap(1'b1);
    send_run(3 * GROUPS_PER_LINE, 1'b1);
    drain();

    // wrap off for the first part of a message, on for the rest, which
    // runs past the wrap point
    set_wrap(1'b0);
    send_run(30, 1'b0);
    drain();
    set_wrap(1'b1);
    send_run(30, 1'b1);
    drain();

    // spare register index must be ignored
    apb_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF, rd);
    check_wrap_reg();

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  set_wrap(1'b0); end
        1: begin sender_idle_pct = 80; recv_stall_pct = 0;  set_wrap(1'b1); end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 80; set_wrap(1'b0); end
        default: begin sender_idle_pct = 23; recv_stall_pct = 23; set_wrap(1'b1); end
      endcase
      run_random(20);
    end

    drain();
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("bytes %0d in %0d messages, %0d chars checked, %0d newlines, %0d mismatches",
             bytes_sent, messages_sent, chars_checked, newlines_seen, mismatches);
    $display("covered padding/flush per group position, wrap points, mid-message wrap",
             " change, spare register and four idling phases");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/b64e_pkg.sv
design/b64e_if.sv
design/b64e_regs.sv
design/b64e_encode.sv
design/b64e_serializer.sv
design/base64_stream_encoder.sv
verif/tb_base64_stream_encoder.sv
